@@ rtl/cbs_pkg.sv @@
// Package for the cubic Bezier subdivision block: control word types and the
// microcode program of the step sequencer.
// No dependencies; imported by cubic_bezier_subdivision_top.
`timescale 1ns / 1ps

package cbs_pkg;

   // Width of the depth configuration register.
   localparam int DEPTH_W = 3;
   // Depth after reset.
   localparam logic [DEPTH_W-1:0] DEPTH_RESET = 3'd4;
   // Width of the microcode step counter.
   localparam int STEP_W = 4;

   typedef enum logic [3:0] {
      OP_IDLE,
      OP_TEST,
      OP_MID1,
      OP_MID2,
      OP_MID3,
      OP_EMIT_B,
      OP_EMIT_C,
      OP_EMIT_D,
      OP_POP
   } op_type;

   typedef enum logic [2:0] {
      COND_NEXT,
      COND_ALWAYS,
      COND_MOVE,
      COND_LEVEL_ZERO,
      COND_STACK_EMPTY
   } cond_type;

   typedef struct packed {
      op_type              op;
      cond_type            cond;
      logic [STEP_W-1:0]   target;
   } ctrl_word_type;

   // Step addresses of the program.
   localparam logic [STEP_W-1:0] ST_IDLE   = 4'd0;
   localparam logic [STEP_W-1:0] ST_TEST   = 4'd1;
   localparam logic [STEP_W-1:0] ST_MID1   = 4'd2;
   localparam logic [STEP_W-1:0] ST_MID2   = 4'd3;
   localparam logic [STEP_W-1:0] ST_MID3   = 4'd4;
   localparam logic [STEP_W-1:0] ST_EMIT_B = 4'd5;
   localparam logic [STEP_W-1:0] ST_EMIT_C = 4'd6;
   localparam logic [STEP_W-1:0] ST_EMIT_D = 4'd7;
   localparam logic [STEP_W-1:0] ST_POP    = 4'd8;

   // When the condition holds the sequencer jumps to target, else it goes on
   // to the next step.
   function automatic ctrl_word_type ucode_rom(input logic [STEP_W-1:0] step);
      ctrl_word_type w;
      unique case (step)
         ST_IDLE:   w = '{op: OP_IDLE,   cond: COND_MOVE,        target: ST_IDLE};
         ST_TEST:   w = '{op: OP_TEST,   cond: COND_LEVEL_ZERO,  target: ST_EMIT_B};
         ST_MID1:   w = '{op: OP_MID1,   cond: COND_NEXT,        target: ST_IDLE};
         ST_MID2:   w = '{op: OP_MID2,   cond: COND_NEXT,        target: ST_IDLE};
         ST_MID3:   w = '{op: OP_MID3,   cond: COND_ALWAYS,      target: ST_TEST};
         ST_EMIT_B: w = '{op: OP_EMIT_B, cond: COND_NEXT,        target: ST_IDLE};
         ST_EMIT_C: w = '{op: OP_EMIT_C, cond: COND_NEXT,        target: ST_IDLE};
         ST_EMIT_D: w = '{op: OP_EMIT_D, cond: COND_STACK_EMPTY, target: ST_IDLE};
         ST_POP:    w = '{op: OP_POP,    cond: COND_ALWAYS,      target: ST_TEST};
         default:   w = '{op: OP_IDLE,   cond: COND_ALWAYS,      target: ST_IDLE};
      endcase
      return w;
   endfunction

endpackage

@@ rtl/cubic_bezier_subdivision_top.sv @@
// Cubic Bezier flattening by midpoint subdivision, driven by a microcoded
// step sequencer. Depends on cbs_pkg for the control words and the program.
`timescale 1ns / 1ps

// A move item sets the pen and gives no result. A curve item is
// split depth times (depth register, values above MAX_DEPTH act as MAX_DEPTH)
// and gives 3 * 2^depth segments, the last one flagged by rsp_tlast. The
// sequencer runs one control word per cycle while the result side does not
// stall an emit step: each split costs four steps (test and three midpoint
// stages), each leaf a test, three emit steps and, but for the last leaf, a
// pop. The next item is taken as soon as the last segment sits in the output
// register.
module cubic_bezier_subdivision_top #(
   parameter int MAX_DEPTH  = 4,
   parameter int COORD_BITS = 10,
   parameter int FRAC_BITS  = 12
) (
   input  logic                                    clock,
   input  logic                                    reset,
   // Configuration: depth.
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [cbs_pkg::DEPTH_W-1:0]             csr_data,
   // Items in.
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   // Fields from bit 0 up: b_x, b_y, c_x, c_y, d_x, d_y, zero fill.
   input  logic [((6*COORD_BITS+7)/8)*8-1:0]       req_tdata,
   // Field: command (0 move, 1 curve).
   input  logic                                    req_tuser,
   // Segments out.
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   // Fields from bit 0 up: start_x, start_y, end_x, end_y, zero fill.
   output logic [((4*COORD_BITS+7)/8)*8-1:0]       rsp_tdata,
   output logic                                    rsp_tlast
);
   import cbs_pkg::*;

   localparam int FX_W  = COORD_BITS + FRAC_BITS;
   localparam int LVL_W = $clog2(MAX_DEPTH + 1);
   localparam int IDX_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
   localparam int RSP_W = ((4*COORD_BITS+7)/8)*8;

   typedef struct packed {
      logic [FX_W-1:0] x;
      logic [FX_W-1:0] y;
   } fpt_type;

   function automatic fpt_type mid_pt(input fpt_type p, input fpt_type q);
      logic [FX_W:0] sx;
      logic [FX_W:0] sy;
      fpt_type       r;
      sx  = {1'b0, p.x} + {1'b0, q.x};
      sy  = {1'b0, p.y} + {1'b0, q.y};
      r.x = sx[FX_W:1];
      r.y = sy[FX_W:1];
      return r;
   endfunction

   function automatic logic [FX_W-1:0] to_fix(input logic [COORD_BITS-1:0] v);
      return {v, {FRAC_BITS{1'b0}}};
   endfunction

   ctrl_word_type         ctrl;
   logic                  slot_free;
   logic                  advance;
   logic                  cond_hit;

   logic [STEP_W-1:0]     step_ff, step_in;
   logic [DEPTH_W-1:0]    depth_ff, depth_in;
   logic [COORD_BITS-1:0] pen_x_ff, pen_x_in;
   logic [COORD_BITS-1:0] pen_y_ff, pen_y_in;
   logic [LVL_W-1:0]      level_ff, level_in;
   logic [MAX_DEPTH-1:0]  valid_ff, valid_in;
   fpt_type               b_ff, b_in, c_ff, c_in, d_ff, d_in;
   fpt_type               ab_ff, ab_in, bc_ff, bc_in, cd_ff, cd_in;
   fpt_type               abc_ff, abc_in, bcd_ff, bcd_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [COORD_BITS-1:0] sx_ff, sx_in, sy_ff, sy_in, ex_ff, ex_in, ey_ff, ey_in;
   logic                  last_ff, last_in;

   // Waiting right halves, one slot per remaining level.
   fpt_type               stk_b_ff [MAX_DEPTH];
   fpt_type               stk_c_ff [MAX_DEPTH];
   fpt_type               stk_d_ff [MAX_DEPTH];
   logic                  push_en;
   logic [IDX_W-1:0]      push_idx;
   logic [IDX_W-1:0]      pop_idx;

   fpt_type               pen_fx;
   fpt_type               emit_pt;
   logic [LVL_W-1:0]      lim;

   assign csr_ready  = 1'b1;
   assign req_tready = (ctrl.op == OP_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tdata  = RSP_W'({ey_ff, ex_ff, sy_ff, sx_ff});

   always_comb begin
      ctrl      = ucode_rom(step_ff);
      slot_free = !rsp_valid_ff || rsp_tready;
      pen_fx.x  = to_fix(pen_x_ff);
      pen_fx.y  = to_fix(pen_y_ff);
      lim       = (depth_ff > DEPTH_W'(MAX_DEPTH)) ? LVL_W'(MAX_DEPTH) : LVL_W'(depth_ff);
      push_idx  = IDX_W'(level_ff - 1'b1);

      // The lowest waiting level is the most recently pushed half.
      pop_idx = '0;
      for (int i = MAX_DEPTH - 1; i >= 0; i--) begin
         if (valid_ff[i]) begin
            pop_idx = IDX_W'(i);
         end
      end

      unique case (ctrl.op)
         OP_IDLE:                       advance = req_tvalid;
         OP_EMIT_B, OP_EMIT_C, OP_EMIT_D: advance = slot_free;
         default:                       advance = 1'b1;
      endcase

      unique case (ctrl.cond)
         COND_NEXT:        cond_hit = 1'b0;
         COND_ALWAYS:      cond_hit = 1'b1;
         COND_MOVE:        cond_hit = !req_tuser;
         COND_LEVEL_ZERO:  cond_hit = (level_ff == '0);
         COND_STACK_EMPTY: cond_hit = (valid_ff == '0);
         default:          cond_hit = 1'b0;
      endcase

      step_in = advance ? (cond_hit ? ctrl.target : STEP_W'(step_ff + 1'b1)) : step_ff;

      depth_in     = csr_valid ? csr_data : depth_ff;
      pen_x_in     = pen_x_ff;
      pen_y_in     = pen_y_ff;
      level_in     = level_ff;
      valid_in     = valid_ff;
      b_in         = b_ff;
      c_in         = c_ff;
      d_in         = d_ff;
      ab_in        = ab_ff;
      bc_in        = bc_ff;
      cd_in        = cd_ff;
      abc_in       = abc_ff;
      bcd_in       = bcd_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      sx_in        = sx_ff;
      sy_in        = sy_ff;
      ex_in        = ex_ff;
      ey_in        = ey_ff;
      last_in      = last_ff;
      push_en      = 1'b0;

      unique case (ctrl.op)
         OP_EMIT_B: emit_pt = b_ff;
         OP_EMIT_C: emit_pt = c_ff;
         default:   emit_pt = d_ff;
      endcase

      unique case (ctrl.op)
         OP_IDLE: begin
            if (req_tvalid) begin
               if (!req_tuser) begin
                  pen_x_in = req_tdata[4*COORD_BITS +: COORD_BITS];
                  pen_y_in = req_tdata[5*COORD_BITS +: COORD_BITS];
               end else begin
                  b_in.x   = to_fix(req_tdata[0 +: COORD_BITS]);
                  b_in.y   = to_fix(req_tdata[COORD_BITS +: COORD_BITS]);
                  c_in.x   = to_fix(req_tdata[2*COORD_BITS +: COORD_BITS]);
                  c_in.y   = to_fix(req_tdata[3*COORD_BITS +: COORD_BITS]);
                  d_in.x   = to_fix(req_tdata[4*COORD_BITS +: COORD_BITS]);
                  d_in.y   = to_fix(req_tdata[5*COORD_BITS +: COORD_BITS]);
                  level_in = lim;
                  valid_in = '0;
               end
            end
         end
         OP_TEST: begin
         end
         OP_MID1: begin
            ab_in = mid_pt(pen_fx, b_ff);
            bc_in = mid_pt(b_ff, c_ff);
            cd_in = mid_pt(c_ff, d_ff);
         end
         OP_MID2: begin
            abc_in = mid_pt(ab_ff, bc_ff);
            bcd_in = mid_pt(bc_ff, cd_ff);
         end
         OP_MID3: begin
            // The right half waits on the stack; the left half goes on.
            push_en            = 1'b1;
            valid_in[push_idx] = 1'b1;
            level_in           = LVL_W'(level_ff - 1'b1);
            b_in               = ab_ff;
            c_in               = abc_ff;
            d_in               = mid_pt(abc_ff, bcd_ff);
         end
         OP_EMIT_B, OP_EMIT_C, OP_EMIT_D: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               sx_in        = pen_x_ff;
               sy_in        = pen_y_ff;
               ex_in        = emit_pt.x[FX_W-1:FRAC_BITS];
               ey_in        = emit_pt.y[FX_W-1:FRAC_BITS];
               last_in      = (ctrl.op == OP_EMIT_D) && (valid_ff == '0);
               pen_x_in     = emit_pt.x[FX_W-1:FRAC_BITS];
               pen_y_in     = emit_pt.y[FX_W-1:FRAC_BITS];
            end
         end
         OP_POP: begin
            valid_in[pop_idx] = 1'b0;
            level_in          = LVL_W'(pop_idx);
            b_in              = stk_b_ff[pop_idx];
            c_in              = stk_c_ff[pop_idx];
            d_in              = stk_d_ff[pop_idx];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= ST_IDLE;
         depth_ff     <= DEPTH_RESET;
         pen_x_ff     <= '0;
         pen_y_ff     <= '0;
         level_ff     <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         depth_ff     <= depth_in;
         pen_x_ff     <= pen_x_in;
         pen_y_ff     <= pen_y_in;
         level_ff     <= level_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      b_ff   <= b_in;
      c_ff   <= c_in;
      d_ff   <= d_in;
      ab_ff  <= ab_in;
      bc_ff  <= bc_in;
      cd_ff  <= cd_in;
      abc_ff <= abc_in;
      bcd_ff <= bcd_in;
      sx_ff  <= sx_in;
      sy_ff  <= sy_in;
      ex_ff  <= ex_in;
      ey_ff  <= ey_in;
      last_ff <= last_in;
      if (push_en) begin
         stk_b_ff[push_idx] <= bcd_ff;
         stk_c_ff[push_idx] <= cd_ff;
         stk_d_ff[push_idx] <= d_ff;
      end
   end

endmodule
